// ===== src/rvie_pkg.sv =====
// Shared types and constants of the RV32I integer execute block.
`default_nettype none
package rvie_pkg;

  localparam int unsigned XLEN     = 32;
  localparam int unsigned REG_AW   = 5;
  localparam int unsigned REG_NUM  = 32;
  localparam int unsigned OFF_W    = 13;

  // Major opcodes handled by the block.
  typedef enum logic [6:0] {
    OPC_OP_IMM = 7'b0010011,
    OPC_OP     = 7'b0110011,
    OPC_BRANCH = 7'b1100011,
    OPC_LUI    = 7'b0110111,
    OPC_AUIPC  = 7'b0010111
  } opcode_e;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  // funct3 codes of the ALU group.
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // funct3 codes of the branch group.
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  // One execute result.
  typedef struct packed {
    logic                    writes_register;
    logic [REG_AW-1:0]       dest_index;
    logic [XLEN-1:0]         write_value;
    logic                    branch_taken;
    logic signed [OFF_W-1:0] branch_offset;
    logic                    undefined_op;
  } exec_res_t;

  // Register file write request.
  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] addr;
    logic [XLEN-1:0]   data;
  } rf_wr_t;

endpackage : rvie_pkg
`default_nettype wire

// ===== src/rvie_regfile.sv =====
// Register file with two registered read ports, write-first bypass and reset valid bits.
`default_nettype none
module rvie_regfile
  import rvie_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire rf_wr_t            wr_i,
  input  wire logic              rd_en_i,
  input  wire logic [REG_AW-1:0] rd_addr1_i,
  input  wire logic [REG_AW-1:0] rd_addr2_i,
  output logic [XLEN-1:0]        rd_data1_o,
  output logic [XLEN-1:0]        rd_data2_o
);

  logic [XLEN-1:0]    mem [REG_NUM];
  logic [REG_NUM-1:0] valid_q;
  logic [XLEN-1:0]    rdat1_q, rdat2_q, byp_data_q;
  logic               vld1_q, vld2_q, byp1_q, byp2_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdat1_q    <= mem[rd_addr1_i];
      rdat2_q    <= mem[rd_addr2_i];
      byp_data_q <= wr_i.data;
    end
  end

  // Entries never written since reset read as zero; x0 is never written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      vld1_q  <= 1'b0;
      vld2_q  <= 1'b0;
      byp1_q  <= 1'b0;
      byp2_q  <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        vld1_q <= valid_q[rd_addr1_i];
        vld2_q <= valid_q[rd_addr2_i];
        byp1_q <= wr_i.en && (wr_i.addr == rd_addr1_i);
        byp2_q <= wr_i.en && (wr_i.addr == rd_addr2_i);
      end
    end
  end

  assign rd_data1_o = byp1_q ? byp_data_q : (vld1_q ? rdat1_q : '0);
  assign rd_data2_o = byp2_q ? byp_data_q : (vld2_q ? rdat2_q : '0);

endmodule : rvie_regfile
`default_nettype wire

// ===== src/rvie_alu.sv =====
// Decode and single-pass execute of OP-IMM, OP, LUI, AUIPC and BRANCH.
`default_nettype none
module rvie_alu
  import rvie_pkg::*;
(
  input  wire logic [XLEN-1:0] instr_i,
  input  wire logic [XLEN-1:0] pc_i,
  input  wire logic [XLEN-1:0] rs1_i,
  input  wire logic [XLEN-1:0] rs2_i,
  output exec_res_t            res_o
);

  logic [6:0]        opc, f7;
  logic [2:0]        f3;
  logic [REG_AW-1:0] rd, shamt;
  logic [XLEN-1:0]   imm_i, imm_u, val;
  logic [OFF_W-1:0]  imm_b;
  logic              wr, taken, undef;

  assign opc   = instr_i[6:0];
  assign rd    = instr_i[11:7];
  assign f3    = instr_i[14:12];
  assign f7    = instr_i[31:25];
  assign shamt = instr_i[24:20];
  assign imm_i = {{(XLEN-12){instr_i[31]}}, instr_i[31:20]};
  assign imm_u = {instr_i[31:12], 12'b0};
  assign imm_b = {instr_i[31], instr_i[7], instr_i[30:25], instr_i[11:8], 1'b0};

  always_comb begin
    val   = '0;
    wr    = 1'b0;
    taken = 1'b0;
    undef = 1'b0;
    case (opc)
      OPC_OP_IMM: begin
        wr = 1'b1;
        case (f3)
          F3_ADD:  val = rs1_i + imm_i;
          F3_SLL: begin
            if (f7 == F7_BASE) val = rs1_i << shamt;
            else undef = 1'b1;
          end
          F3_SLT:  val = {{(XLEN-1){1'b0}}, $signed(rs1_i) < $signed(imm_i)};
          F3_SLTU: val = {{(XLEN-1){1'b0}}, rs1_i < imm_i};
          F3_XOR:  val = rs1_i ^ imm_i;
          F3_SR: begin
            if (f7 == F7_BASE) val = rs1_i >> shamt;
            else if (f7 == F7_ALT) val = XLEN'($signed(rs1_i) >>> shamt);
            else undef = 1'b1;
          end
          F3_OR:   val = rs1_i | imm_i;
          default: val = rs1_i & imm_i;
        endcase
      end
      OPC_OP: begin
        wr = 1'b1;
        if (f7 == F7_BASE) begin
          case (f3)
            F3_ADD:  val = rs1_i + rs2_i;
            F3_SLL:  val = rs1_i << rs2_i[REG_AW-1:0];
            F3_SLT:  val = {{(XLEN-1){1'b0}}, $signed(rs1_i) < $signed(rs2_i)};
            F3_SLTU: val = {{(XLEN-1){1'b0}}, rs1_i < rs2_i};
            F3_XOR:  val = rs1_i ^ rs2_i;
            F3_SR:   val = rs1_i >> rs2_i[REG_AW-1:0];
            F3_OR:   val = rs1_i | rs2_i;
            default: val = rs1_i & rs2_i;
          endcase
        end else if (f7 == F7_ALT && f3 == F3_ADD) begin
          val = rs1_i - rs2_i;
        end else if (f7 == F7_ALT && f3 == F3_SR) begin
          val = XLEN'($signed(rs1_i) >>> rs2_i[REG_AW-1:0]);
        end else begin
          undef = 1'b1;
        end
      end
      OPC_LUI: begin
        wr  = 1'b1;
        val = imm_u;
      end
      OPC_AUIPC: begin
        wr  = 1'b1;
        val = pc_i + imm_u;
      end
      OPC_BRANCH: begin
        case (f3)
          F3_BEQ:  taken = (rs1_i == rs2_i);
          F3_BNE:  taken = (rs1_i != rs2_i);
          F3_BLT:  taken = ($signed(rs1_i) < $signed(rs2_i));
          F3_BGE:  taken = !($signed(rs1_i) < $signed(rs2_i));
          F3_BLTU: taken = (rs1_i < rs2_i);
          F3_BGEU: taken = (rs1_i >= rs2_i);
          default: undef = 1'b1;
        endcase
      end
      default: undef = 1'b1;
    endcase

    // Undefined encodings change nothing; writes to x0 are dropped.
    if (undef) begin
      wr    = 1'b0;
      taken = 1'b0;
    end
    if (rd == '0) begin
      wr = 1'b0;
    end
  end

  assign res_o.writes_register = wr;
  assign res_o.dest_index      = wr ? rd : '0;
  assign res_o.write_value     = wr ? val : '0;
  assign res_o.branch_taken    = taken;
  assign res_o.branch_offset   = taken ? $signed(imm_b) : '0;
  assign res_o.undefined_op    = undef;

endmodule : rvie_alu
`default_nettype wire

// ===== src/rv32i_integer_execute.sv =====
// Top level of the RV32I integer execute block: input register, execute, result register.
//
//  Channel  Direction  Beat carries
//  s_axis   in         one instruction word and its PC
//  m_axis   out        one execute result (write-back, branch, undefined flag)
//
// Every input beat gives exactly one result beat, by way of the input register
// and the result register; it sustains one beat per clock unless m_axis stalls.
// Operand reads start from the incoming beat into the registered register file
// ports; the write of the instruction in execute is bypassed to the next one.
// Reset clears the valid flags and the register file contents read as zero.
// When the result register is full and not taken, execute stalls and the input
// register holds, so s_axis_tready_o drops only while both stages are occupied.
`default_nettype none
module rv32i_integer_execute
  import rvie_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // [31:0] instruction, [63:32] current_pc
  input  wire logic [63:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [0] writes_register, [5:1] dest_index, [37:6] write_value,
  // [38] branch_taken, [51:39] branch_offset, [55:52] zero
  output logic [55:0]      m_axis_tdata_o,
  // [0] undefined_op
  output logic             m_axis_tuser_o
);

  logic            in_valid_q;
  logic [XLEN-1:0] instr_q, pc_q;
  logic            in_accept, exec_fire;
  logic            out_valid_q;
  exec_res_t       res, res_q;
  logic [XLEN-1:0] rs1, rs2;
  rf_wr_t          rf_wr;

  // Execute moves an instruction into the result register when that register
  // is empty or is being drained in the same cycle.
  assign exec_fire       = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || exec_fire;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (exec_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      instr_q <= s_axis_tdata_i[31:0];
      pc_q    <= s_axis_tdata_i[63:32];
    end
    if (exec_fire) begin
      res_q <= res;
    end
  end

  // The register file is written when an instruction that writes a register leaves execute.
  assign rf_wr.en   = exec_fire && res.writes_register;
  assign rf_wr.addr = res.dest_index;
  assign rf_wr.data = res.write_value;

  rvie_regfile u_regfile (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (rf_wr),
    .rd_en_i    (in_accept),
    .rd_addr1_i (s_axis_tdata_i[19:15]),
    .rd_addr2_i (s_axis_tdata_i[24:20]),
    .rd_data1_o (rs1),
    .rd_data2_o (rs2)
  );

  rvie_alu u_alu (
    .instr_i (instr_q),
    .pc_i    (pc_q),
    .rs1_i   (rs1),
    .rs2_i   (rs2),
    .res_o   (res)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'b0, res_q.branch_offset, res_q.branch_taken,
                            res_q.write_value, res_q.dest_index, res_q.writes_register};
  assign m_axis_tuser_o  = res_q.undefined_op;

endmodule : rv32i_integer_execute
`default_nettype wire

// ===== tb/rv32i_integer_execute_test.sv =====
// Self-checking testbench for the RV32I integer execute block.
`timescale 1ns / 100ps
module rv32i_integer_execute_test;
  import rvie_pkg::*;

  // Opcode and funct7 values that the block must flag as undefined.
  localparam logic [6:0] OPC_LOAD = 7'b0000011;
  localparam logic [6:0] F7_ODD   = 7'h01;

  // Reserved funct3 codes of the branch group, and the word load funct3.
  localparam logic [2:0] F3_BR_RSV_A = 3'd2;
  localparam logic [2:0] F3_BR_RSV_B = 3'd3;
  localparam logic [2:0] F3_LW       = 3'd2;

  // A correct run stays well inside this limit even with both sides stalling as
  // long as they can, so this leaves a wide margin.
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [55:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;

  // Architectural register file as the testbench expects it to be.
  logic [31:0] arch_regs [REG_NUM] = '{default: '0};

  // Results that accepted instructions must still produce, oldest first.
  exec_res_t   pending_results [$];

  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned instrs_sent = 0;
  int unsigned writes_seen = 0;
  int unsigned taken_seen = 0;
  int unsigned undef_seen = 0;

  // When set, neither side inserts idle cycles.
  bit          no_idle = 1'b0;

  rv32i_integer_execute DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, pending_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Instruction encoders.
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                        input logic [4:0] rs1, input logic [2:0] f3,
                                        input logic [4:0] rd, input logic [6:0] opc);
    return {f7, rs2, rs1, f3, rd, opc};
  endfunction

  function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
                                        input logic [2:0] f3, input logic [4:0] rd);
    return {imm, rs1, f3, rd, OPC_OP_IMM};
  endfunction

  function automatic logic [31:0] enc_u(input logic [19:0] imm, input logic [4:0] rd,
                                        input logic [6:0] opc);
    return {imm, rd, opc};
  endfunction

  function automatic logic [31:0] enc_b(input logic [12:0] off, input logic [4:0] rs2,
                                        input logic [4:0] rs1, input logic [2:0] f3);
    return {off[12], off[10:5], rs2, rs1, f3, off[4:1], off[11], OPC_BRANCH};
  endfunction

  // ---------------------------------------------------------------------------
  // Execute prediction. Works out the result of one instruction against the
  // expected register file and applies its write-back.
  // ---------------------------------------------------------------------------
  function automatic exec_res_t execute_instr(input logic [31:0] ins, input logic [31:0] pc);
    exec_res_t   res;
    logic [6:0]  f7;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [4:0]  shamt;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] imm;
    logic [31:0] val;
    logic [12:0] off;
    logic        wr;
    logic        taken;
    logic        undef;

    f7    = ins[31:25];
    f3    = ins[14:12];
    rd    = ins[11:7];
    shamt = ins[24:20];
    a     = arch_regs[ins[19:15]];
    b     = arch_regs[ins[24:20]];
    imm   = {{20{ins[31]}}, ins[31:20]};
    val   = '0;
    off   = '0;
    wr    = 1'b0;
    taken = 1'b0;
    undef = 1'b0;

    case (ins[6:0])
      OPC_OP_IMM: begin
        wr = 1'b1;
        case (f3)
          F3_ADD:  val = a + imm;
          F3_SLL: begin
            if (f7 == F7_BASE) val = a << shamt;
            else undef = 1'b1;
          end
          F3_SLT:  val = {31'b0, $signed(a) < $signed(imm)};
          F3_SLTU: val = {31'b0, a < imm};
          F3_XOR:  val = a ^ imm;
          F3_SR: begin
            if (f7 == F7_BASE) val = a >> shamt;
            else if (f7 == F7_ALT) val = $signed(a) >>> shamt;
            else undef = 1'b1;
          end
          F3_OR:   val = a | imm;
          default: val = a & imm;
        endcase
      end
      OPC_OP: begin
        wr = 1'b1;
        if (f7 == F7_BASE) begin
          // Register shifts use only the low five bits of rs2.
          case (f3)
            F3_ADD:  val = a + b;
            F3_SLL:  val = a << b[4:0];
            F3_SLT:  val = {31'b0, $signed(a) < $signed(b)};
            F3_SLTU: val = {31'b0, a < b};
            F3_XOR:  val = a ^ b;
            F3_SR:   val = a >> b[4:0];
            F3_OR:   val = a | b;
            default: val = a & b;
          endcase
        end else if (f7 == F7_ALT && f3 == F3_ADD) begin
          val = a - b;
        end else if (f7 == F7_ALT && f3 == F3_SR) begin
          val = $signed(a) >>> b[4:0];
        end else begin
          undef = 1'b1;
        end
      end
      OPC_LUI: begin
        wr  = 1'b1;
        val = {ins[31:12], 12'b0};
      end
      OPC_AUIPC: begin
        wr  = 1'b1;
        val = pc + {ins[31:12], 12'b0};
      end
      OPC_BRANCH: begin
        case (f3)
          F3_BEQ:  taken = (a == b);
          F3_BNE:  taken = (a != b);
          F3_BLT:  taken = $signed(a) < $signed(b);
          F3_BGE:  taken = $signed(a) >= $signed(b);
          F3_BLTU: taken = a < b;
          F3_BGEU: taken = a >= b;
          default: undef = 1'b1;
        endcase
        if (taken) off = {ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
      end
      default: undef = 1'b1;
    endcase

    // Undefined encodings leave every other field at zero and the state alone.
    if (undef) begin
      wr    = 1'b0;
      taken = 1'b0;
      off   = '0;
    end
    // A write to x0 executes but is dropped.
    if (wr && rd == '0) wr = 1'b0;
    if (wr) arch_regs[rd] = val;

    res.writes_register = wr;
    res.dest_index      = wr ? rd : '0;
    res.write_value     = wr ? val : '0;
    res.branch_taken    = taken;
    res.branch_offset   = taken ? off : '0;
    res.undefined_op    = undef;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Handshake helpers.
  // ---------------------------------------------------------------------------
  function automatic int unsigned draw_gap();
    if (no_idle) return 0;
    return $urandom_range(0, 17);
  endfunction

  // Sends one instruction beat. The valid stays high after acceptance so that
  // a following beat with no gap keeps the bus busy without a dip.
  task automatic send_instr(input logic [31:0] ins, input logic [31:0] pc);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {pc, ins};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_results.push_back(execute_instr(ins, pc));
    instrs_sent++;
  endtask

  // Lowers the input valid and waits until every expected result has come.
  task automatic wait_results_drained();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, name, want, got);
      mismatches++;
    end
  endtask

  // Result side: random stalls on tready, and every accepted beat is checked
  // against the oldest outstanding prediction.
  initial begin
    exec_res_t   want;
    logic [55:0] got;
    int unsigned stall;
    wait (rst_ni === 1'b1);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid_o && m_axis_tready_i));
      got = m_axis_tdata_o;
      if (pending_results.size() == 0) begin
        $display("%0t ns: result beat with nothing expected, actual tdata 0x%0h tuser %0b",
                 $time, got, m_axis_tuser_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("writes_register", 32'(want.writes_register), 32'(got[0]));
        check_field("dest_index", 32'(want.dest_index), 32'(got[5:1]));
        check_field("write_value", want.write_value, got[37:6]);
        check_field("branch_taken", 32'(want.branch_taken), 32'(got[38]));
        check_field("branch_offset", {19'b0, want.branch_offset}, {19'b0, got[51:39]});
        check_field("tdata padding", 32'h0, 32'(got[55:52]));
        check_field("undefined_op", 32'(want.undefined_op), 32'(m_axis_tuser_o));
        writes_seen += int'(want.writes_register);
        taken_seen  += int'(want.branch_taken);
        undef_seen  += int'(want.undefined_op);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Random instruction source. Mostly well-formed instructions with random
  // content; registers are drawn mostly from the low half so that values
  // written earlier feed later operands. A small share is raw noise.
  // ---------------------------------------------------------------------------
  function automatic logic [4:0] pick_reg();
    if ($urandom_range(0, 7) == 0) return 5'($urandom_range(16, 31));
    return 5'($urandom_range(0, 15));
  endfunction

  function automatic logic [6:0] pick_f7(input logic [2:0] f3);
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 7'($urandom);
    if (roll < 4 && (f3 == F3_ADD || f3 == F3_SR)) return F7_ALT;
    return F7_BASE;
  endfunction

  function automatic logic [31:0] random_instr();
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [2:0]  f3;
    int unsigned kind;
    rd   = pick_reg();
    rs1  = pick_reg();
    rs2  = ($urandom_range(0, 4) == 0) ? rs1 : pick_reg();
    f3   = 3'($urandom);
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      if (f3 == F3_SLL || f3 == F3_SR)
        return enc_r(pick_f7(f3), 5'($urandom), rs1, f3, rd, OPC_OP_IMM);
      return enc_i(12'($urandom), rs1, f3, rd);
    end
    if (kind < 55) return enc_r(pick_f7(f3), rs2, rs1, f3, rd, OPC_OP);
    if (kind < 63) return enc_u(20'($urandom), rd, OPC_LUI);
    if (kind < 70) return enc_u(20'($urandom), rd, OPC_AUIPC);
    if (kind < 93) return enc_b(13'($urandom), rs2, rs1, f3);
    return $urandom;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Operand extremes, every immediate operation and branch condition, writes to x0, shift
  // amounts taken from the low bits of rs2, extreme branch offsets and the undefined encodings.
  task automatic test_directed();
    send_instr(enc_i(12'hFFF, 5'd0, F3_ADD, 5'd1), 32'h0);             // x1 = -1
    send_instr(enc_u(20'h80000, 5'd2, OPC_LUI), 32'h4);                 // x2 = INT_MIN
    send_instr(enc_i(12'hFFF, 5'd2, F3_ADD, 5'd3), 32'h8);             // x3 = INT_MAX
    send_instr(enc_i(12'h7FF, 5'd0, F3_OR, 5'd4), 32'hC);              // x4 = 0x7FF
    send_instr(enc_i(12'h005, 5'd1, F3_ADD, 5'd0), 32'h10);            // dropped write
    send_instr(enc_u(20'hFFFFF, 5'd5, OPC_AUIPC), 32'hFFFFFFFF);
    send_instr(enc_i(12'h000, 5'd2, F3_SLT, 5'd6), 32'h0);
    send_instr(enc_i(12'hFFF, 5'd1, F3_SLTU, 5'd7), 32'h0);
    send_instr(enc_i(12'h800, 5'd3, F3_XOR, 5'd8), 32'h0);
    send_instr(enc_i(12'h800, 5'd1, F3_AND, 5'd9), 32'h0);
    send_instr(enc_r(F7_ALT, 5'd31, 5'd2, F3_SR, 5'd10, OPC_OP_IMM), 32'h0);
    send_instr(enc_r(F7_BASE, 5'd31, 5'd1, F3_SLL, 5'd11, OPC_OP_IMM), 32'h0);
    send_instr(enc_r(F7_BASE, 5'd1, 5'd1, F3_SR, 5'd12, OPC_OP_IMM), 32'h0);
    send_instr(enc_r(F7_ALT, 5'd4, 5'd2, F3_ADD, 5'd13, OPC_OP), 32'h0);  // wraps
    send_instr(enc_r(F7_ALT, 5'd1, 5'd2, F3_SR, 5'd14, OPC_OP), 32'h0);   // by 31
    send_instr(enc_r(F7_BASE, 5'd4, 5'd1, F3_SLL, 5'd15, OPC_OP), 32'h0);
    send_instr(enc_r(F7_BASE, 5'd3, 5'd2, F3_SLT, 5'd16, OPC_OP), 32'h0);
    send_instr(enc_r(F7_BASE, 5'd3, 5'd2, F3_SLTU, 5'd17, OPC_OP), 32'h0);
    send_instr(enc_b(13'h1000, 5'd3, 5'd2, F3_BLT), 32'h0);             // -4096
    send_instr(enc_b(13'h0FFE, 5'd2, 5'd3, F3_BGE), 32'h0);             // +4094
    send_instr(enc_b(13'h0010, 5'd3, 5'd2, F3_BLTU), 32'h0);            // not taken
    send_instr(enc_b(13'h1FFE, 5'd0, 5'd0, F3_BEQ), 32'h0);
    send_instr(enc_b(13'h0020, 5'd1, 5'd1, F3_BNE), 32'h0);
    send_instr(enc_b(13'h0AAA, 5'd3, 5'd2, F3_BGEU), 32'h0);
    // Unknown encodings.
    send_instr(enc_r(F7_ALT, 5'd3, 5'd1, F3_SLL, 5'd18, OPC_OP_IMM), 32'h0);
    send_instr(enc_r(F7_ODD, 5'd3, 5'd1, F3_SR, 5'd18, OPC_OP_IMM), 32'h0);
    send_instr(enc_r(F7_ODD, 5'd3, 5'd1, F3_ADD, 5'd18, OPC_OP), 32'h0);
    send_instr(enc_r(F7_ALT, 5'd3, 5'd1, F3_XOR, 5'd18, OPC_OP), 32'h0);
    send_instr({7'h0, 5'd2, 5'd1, F3_BR_RSV_A, 5'd0, OPC_BRANCH}, 32'h0);
    send_instr({7'h0, 5'd2, 5'd1, F3_BR_RSV_B, 5'd0, OPC_BRANCH}, 32'h0);
    send_instr({12'h0, 5'd1, F3_LW, 5'd18, OPC_LOAD}, 32'h0);
    send_instr(32'hFFFFFFFF, 32'hFFFFFFFF);
    send_instr(32'h0, 32'h0);
  endtask

  task automatic test_random_traffic(input int unsigned count);
    repeat (count) send_instr(random_instr(), $urandom);
  endtask

  // The sender stops until the block has returned everything, then resumes.
  task automatic test_pause_and_resume(input int unsigned count);
    repeat (count) send_instr(random_instr(), $urandom);
    wait_results_drained();
    repeat (count) send_instr(random_instr(), $urandom);
  endtask

  // Full rate on both sides.
  task automatic test_back_to_back(input int unsigned count);
    no_idle = 1'b1;
    repeat (count) send_instr(random_instr(), $urandom);
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_traffic(500);
    test_pause_and_resume(40);
    test_back_to_back(300);
    test_random_traffic(100);

    wait_results_drained();
    repeat (8) @(posedge clk_i);

    $display("Sent %0d instructions in %0d cycles, with and without stalls on either side.",
             instrs_sent, cycle_count);
    $display("Checked %0d register writes, %0d taken branches, %0d undefined encodings.",
             writes_seen, taken_seen, undef_seen);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
